// ----- hw/rtl/aeta_pkg.sv -----
// Package: shared types, constants and tables for the EMA tilt-angle block.
`timescale 1ns / 1ps
package aeta_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int STEPS        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(TAB_LEN + 1);
  localparam int ONE_G        = 16384;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_DIV  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_DIV, ST_UPD, ST_CORDIC, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture inputs
    logic scale;      // scale all axes
    logic div_start;  // start dividers
    logic update;     // commit averages, set up cordic
    logic cordic;     // one cordic step
    logic finish;     // form output
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
  } sts_t;

  function automatic logic signed [31:0] atan_tab(input logic [STEP_W-1:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd294912000;  5'd1: r = 32'sd174096720;
      5'd2: r = 32'sd91987925;   5'd3: r = 32'sd46694507;
      5'd4: r = 32'sd23437865;   5'd5: r = 32'sd11730358;
      5'd6: r = 32'sd5866610;    5'd7: r = 32'sd2933484;
      5'd8: r = 32'sd1466764;    5'd9: r = 32'sd733385;
      5'd10: r = 32'sd366693;    5'd11: r = 32'sd183346;
      5'd12: r = 32'sd91673;     5'd13: r = 32'sd45837;
      5'd14: r = 32'sd22918;     5'd15: r = 32'sd11459;
      5'd16: r = 32'sd5730;      5'd17: r = 32'sd2865;
      5'd18: r = 32'sd1432;      5'd19: r = 32'sd716;
      5'd20: r = 32'sd358;       5'd21: r = 32'sd179;
      5'd22: r = 32'sd90;        5'd23: r = 32'sd45;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/aeta_ctrl.sv -----
// Controller: sequences scaling, averaging, CORDIC and output handoff.
`timescale 1ns / 1ps
module aeta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_free,
  input  aeta_pkg::sts_t sts,
  output logic           in_stall,
  output aeta_pkg::cmd_t cmd
);
  import aeta_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_UPD;
      end
      ST_UPD: begin
        if (sts.div_done) begin
          cmd.update = 1'b1;
          state_next = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd.cordic = 1'b1;
        if (sts.cordic_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/aeta_div.sv -----
// Restoring divider: signed dividend by unsigned 8-bit divisor, truncating.
`timescale 1ns / 1ps
module aeta_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dividend,
  input  logic [7:0]         divisor,
  output logic signed [32:0] quotient,
  output logic               done
);
  import aeta_pkg::*;

  logic [31:0] rem_q;   // quotient bits shift in from the bottom
  logic [8:0]  rem;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [9:0]  trial;

  assign trial = {rem, rem_q[31]} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == 6'd31) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[32];
      rem_q <= dividend[32] ? 32'(-dividend) : dividend[31:0];
      rem   <= '0;
      cnt   <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!trial[9]) begin
        rem   <= trial[8:0];
        rem_q <= {rem_q[30:0], 1'b1};
      end else begin
        rem   <= {rem[7:0], rem_q[31]};
        rem_q <= {rem_q[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
endmodule

// ----- hw/rtl/aeta_dp.sv -----
// Datapath: scaling, moving averages, dividers and CORDIC vectoring unit.
`timescale 1ns / 1ps
module aeta_dp (
  input  logic                clk,
  input  logic                rst,
  input  aeta_pkg::cmd_t      cmd,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  raw_x,
  input  logic signed [15:0]  raw_y,
  input  logic signed [15:0]  raw_z,
  output aeta_pkg::sts_t      sts,
  output logic signed [14:0]  tilt,
  output logic signed [15:0]  ax,
  output logic signed [15:0]  ay,
  output logic signed [15:0]  az
);
  import aeta_pkg::*;

  logic [15:0] gain;
  logic [7:0]  divr;
  logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
  logic signed [32:0] dx, dy, dz;   // scaled - avg
  logic signed [32:0] qx, qy, qz;
  logic d0, d1, d2;
  logic [7:0] div_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 16'd16357;
      divr <= 8'd8;
    end else if (cfg_we) begin
      if (cfg_idx == REG_GAIN) gain <= cfg_data;
      else if (cfg_idx == REG_DIV) divr <= cfg_data[7:0];
    end
  end

  assign div_eff = (divr == 8'd0) ? 8'd1 : divr;

  function automatic logic signed [32:0] diff(input logic signed [SAMPLE_BITS-1:0] s,
                                              input logic [15:0] g,
                                              input logic signed [15:0] a);
    logic signed [33:0] p;
    p = $signed({{(34-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s}) * $signed({18'b0, g});
    return 33'(p >>> 8) - 33'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= raw_x[SAMPLE_BITS-1:0];
      sy <= raw_y[SAMPLE_BITS-1:0];
      sz <= raw_z[SAMPLE_BITS-1:0];
    end
    if (cmd.scale) begin
      dx <= diff(sx, gain, ax);
      dy <= diff(sy, gain, ay);
      dz <= diff(sz, gain, az);
    end
  end

  aeta_div u_dx (.clk, .rst, .start(cmd.div_start), .dividend(dx), .divisor(div_eff),
                 .quotient(qx), .done(d0));
  aeta_div u_dy (.clk, .rst, .start(cmd.div_start), .dividend(dy), .divisor(div_eff),
                 .quotient(qy), .done(d1));
  aeta_div u_dz (.clk, .rst, .start(cmd.div_start), .dividend(dz), .divisor(div_eff),
                 .quotient(qz), .done(d2));

  assign sts.div_done = d0 & d1 & d2;

  function automatic logic signed [15:0] clampg(input logic signed [15:0] a,
                                                input logic signed [32:0] q);
    logic signed [33:0] n;
    n = 34'(a) + 34'(q);
    if (n > 34'sd16384) return 16'sd16384;
    if (n < -34'sd16384) return -16'sd16384;
    return n[15:0];
  endfunction

  logic signed [15:0] nx, nz;
  assign nx = clampg(ax, qx);
  assign nz = clampg(az, qz);

  // CORDIC state
  logic signed [26:0] cx, cy;
  logic signed [31:0] ang;
  logic [STEP_W-1:0]  step;
  logic [1:0]         special;   // 0: cordic, 1: +90, 2: -90, 3: zero
  logic signed [26:0] shx, shy;

  assign shx = cy >>> step;
  assign shy = cx >>> step;
  assign sts.cordic_done = (step == STEP_W'(STEPS - 1)) || (special != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0; ay <= '0; az <= '0;
    end else if (cmd.update) begin
      ax <= nx;
      ay <= clampg(ay, qy);
      az <= nz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      step <= '0;
      ang  <= '0;
      cx   <= 27'(nz[15] ? -nz : nz) <<< 8;
      cy   <= 27'(nz[15] ? -nx : nx) <<< 8;
      if (nz == 16'sd0)
        special <= (nx > 0) ? 2'd1 : ((nx < 0) ? 2'd2 : 2'd3);
      else if (nx == 16'sd0)
        special <= 2'd3;
      else
        special <= 2'd0;
    end else if (cmd.cordic && special == 2'd0) begin
      step <= step + STEP_W'(1);
      if (!cy[26]) begin
        cx  <= cx + shx;
        cy  <= cy - shy;
        ang <= ang + atan_tab(step);
      end else begin
        cx  <= cx - shx;
        cy  <= cy + shy;
        ang <= ang - atan_tab(step);
      end
    end
  end

  logic signed [32:0] rnd;
  logic signed [16:0] r;
  assign rnd = (33'(ang) + 33'sd32768) >>> 16;
  assign r   = rnd[16:0];

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (special)
        2'd1: tilt <= 15'sd9000;
        2'd2: tilt <= -15'sd9000;
        2'd3: tilt <= '0;
        default: begin
          if (r > 17'sd9000) tilt <= 15'sd9000;
          else if (r < -17'sd9000) tilt <= -15'sd9000;
          else tilt <= r[14:0];
        end
      endcase
    end
  end
endmodule

// ----- hw/rtl/accel_ema_tilt_angle.sv -----
// Top level: EMA-filtered accelerometer tilt angle with controller and datapath.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid/in_stall carries raw_x/raw_y/raw_z; a transfer
//  happens when in_valid is high and in_stall low. One sample is worked at a
//  time: in_stall is low only while the block is idle.
//  Each sample runs through these steps, transfer to next possible transfer:
//  the capture, one scale step, the divider start, a bit-serial divide
//  (three dividers in parallel, one quotient bit per cycle), the commit of
//  the averages, CORDIC_STEPS (16) vectoring iterations, one per cycle (none
//  for the special cases), and the load of the output register, which waits
//  until the output register is free.
//  Output channel out_valid/out_stall carries tilt_centideg and filt_x/y/z
//  from an output register. The next sample is taken while a result waits;
//  its result holds until the previous one transfers.
//  Configuration: cfg_we, cfg_index, cfg_data write scale_gain (0) or
//  smooth_divisor (1); write only while idle.
//  Reset (rst, synchronous) clears averages to zero, restores gain 16357 and
//  divisor 8, and empties the output register.
module accel_ema_tilt_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] tilt_centideg,
  output logic signed [15:0] filt_x,
  output logic signed [15:0] filt_y,
  output logic signed [15:0] filt_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import aeta_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_free;
  logic signed [14:0] tilt;
  logic signed [15:0] ax, ay, az;

  // output register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  aeta_ctrl u_ctrl (.clk, .rst, .in_valid, .out_free, .sts, .in_stall, .cmd);

  aeta_dp u_dp (.clk, .rst, .cmd, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
                .raw_x, .raw_y, .raw_z, .sts, .tilt, .ax, .ay, .az);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // finish loads tilt in dp this same edge; filt values latch here
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      filt_x <= ax;
      filt_y <= ay;
      filt_z <= az;
    end
  end

  assign tilt_centideg = tilt;
endmodule

// ----- bench/accel_ema_tilt_angle_test.sv -----
// Testbench for the EMA-filtered accelerometer tilt-angle block.
`timescale 1ns / 1ps
module accel_ema_tilt_angle_test;
  import aeta_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD   = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] raw_x = '0;
  logic signed [15:0] raw_y = '0;
  logic signed [15:0] raw_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] tilt_centideg;
  logic signed [15:0] filt_x;
  logic signed [15:0] filt_y;
  logic signed [15:0] filt_z;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_GAIN;
  logic [15:0]        cfg_data = '0;

  accel_ema_tilt_angle dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [14:0] tilt;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
  } tilt_result_t;

  // Directed rows: raw sample plus, where obvious, the expected result.
  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 typed;
    tilt_result_t       res;
  } sample_row_t;

  tilt_result_t pending_results[$];
  int   fail_count = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_recv = 1'b0;

  // Predictor state mirrors the block's registers.
  logic [15:0]        gain_q88;
  logic [7:0]         divisor;
  logic signed [15:0] ema_x, ema_y, ema_z;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] ema_update(logic signed [15:0] avg,
                                                     logic signed [15:0] raw);
    longint scaled, d, nxt;
    scaled = floor_shift(longint'(raw) * longint'(gain_q88), 8);
    d = (divisor == 0) ? 1 : longint'(divisor);
    nxt = longint'(avg) + (scaled - longint'(avg)) / d;  // truncates toward zero
    if (nxt > ONE_G) nxt = ONE_G;
    if (nxt < -ONE_G) nxt = -ONE_G;
    return nxt[15:0];
  endfunction

  function automatic logic signed [14:0] tilt_angle(logic signed [15:0] x,
                                                    logic signed [15:0] z);
    longint vx, vy, ang, dx, dy, r;
    ang = 0;
    if (z == 0) return (x > 0) ? 15'sd9000 : ((x < 0) ? -15'sd9000 : 15'sd0);
    if (x == 0) return 15'sd0;
    // atan of the ratio, so fold negative z into the first half plane
    vx = (z < 0 ? -longint'(z) : longint'(z)) * 256;
    vy = (z < 0 ? -longint'(x) : longint'(x)) * 256;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(vy, i);
      dy = floor_shift(vx, i);
      if (vy >= 0) begin
        vx += dx; vy -= dy; ang += longint'(atan_tab(STEP_W'(i)));
      end else begin
        vx -= dx; vy += dy; ang -= longint'(atan_tab(STEP_W'(i)));
      end
    end
    r = floor_shift(ang + 32768, 16);
    if (r > 9000) r = 9000;
    if (r < -9000) r = -9000;
    return r[14:0];
  endfunction

  function automatic tilt_result_t predict_tilt(logic signed [15:0] x,
                                                logic signed [15:0] y,
                                                logic signed [15:0] z);
    tilt_result_t res;
    ema_x = ema_update(ema_x, x);
    ema_y = ema_update(ema_y, y);
    ema_z = ema_update(ema_z, z);
    res.tilt = tilt_angle(ema_x, ema_z);
    res.fx = ema_x; res.fy = ema_y; res.fz = ema_z;
    return res;
  endfunction

  // One sample transfer; expectation is queued as the transfer is offered.
  // in_valid stays high after the transfer so the next sample can follow;
  // idle cycles and drain() drop it.
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit typed, tilt_result_t typed_res);
    tilt_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    res = predict_tilt(x, y, z);
    if (typed && res != typed_res) begin
      $display("%0t predictor disagrees with table row: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
               $time, typed_res.tilt, typed_res.fx, typed_res.fy, typed_res.fz,
               res.tilt, res.fx, res.fy, res.fz);
      fail_count++;
    end
    pending_results.push_back(typed ? typed_res : res);
    in_valid <= 1'b1;
    raw_x <= x; raw_y <= y; raw_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);  // block may still be busy on nothing, be safe
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GAIN) gain_q88 = val;
    else if (idx == REG_DIV) divisor = val[7:0];
    @(negedge clk);
  endtask

  // Random sample: mostly gravity-like values, some full-range noise.
  task automatic random_samples(int n);
    logic signed [15:0] v[3];
    tilt_result_t none;
    for (int k = 0; k < n; k++) begin
      for (int a = 0; a < 3; a++)
        v[a] = ($urandom_range(3) == 0) ? 16'($urandom)
                                        : 16'($signed($urandom_range(600)) - 300) * 16'sd1;
      if ($urandom_range(9) == 0) v[$urandom_range(2)] = 0;
      send_sample(v[0], v[1], v[2], 1'b0, none);
    end
  endtask

  // Receiver: stalls at random, or for a long stretch when asked.
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker at the rising edge.
  always @(posedge clk) begin
    tilt_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer: tilt %0d", $time, tilt_centideg);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (tilt_centideg !== exp_res.tilt || filt_x !== exp_res.fx ||
            filt_y !== exp_res.fy || filt_z !== exp_res.fz) begin
          $display("%0t mismatch: exp tilt %0d x %0d y %0d z %0d, got %0d %0d %0d %0d",
                   $time, exp_res.tilt, exp_res.fx, exp_res.fy, exp_res.fz,
                   tilt_centideg, filt_x, filt_y, filt_z);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  sample_row_t directed_rows[$];

  function automatic sample_row_t row(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z, bit typed = 1'b0,
                                      int t = 0, int fx = 0, int fy = 0, int fz = 0);
    sample_row_t r;
    r.x = x; r.y = y; r.z = z; r.typed = typed;
    r.res.tilt = 15'(t); r.res.fx = 16'(fx); r.res.fy = 16'(fy); r.res.fz = 16'(fz);
    return r;
  endfunction

  initial begin
    gain_q88 = 16'd16357; divisor = 8'd8;
    ema_x = 0; ema_y = 0; ema_z = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under reset settings: zero sample, z zero with x of each sign,
    // x zero, negative z, then the field extremes.
    directed_rows.push_back(row(0, 0, 0, 1'b1, 0, 0, 0, 0));
    directed_rows.push_back(row(256, 0, 0));
    directed_rows.push_back(row(-1024, 0, 0));
    directed_rows.push_back(row(0, 0, 256));
    directed_rows.push_back(row(100, 50, -300));
    directed_rows.push_back(row(-100, -50, -300));
    directed_rows.push_back(row(16'sh7fff, 16'sh7fff, 16'sh7fff));
    directed_rows.push_back(row(-16'sh8000, -16'sh8000, -16'sh8000));
    directed_rows.push_back(row(16'sh5555, -16'sh2aab, 16'sh0001));
    directed_rows.push_back(row(-16'sh5556, 16'sh2aaa, -16'sh0001));
    foreach (directed_rows[i])
      send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].typed, directed_rows[i].res);
    drain();

    // Divisor one: the average follows the scaled sample, clamped at one g.
    write_reg(REG_DIV, 16'd1);
    write_reg(REG_GAIN, 16'd256);
    send_sample(16'sh7fff, -16'sh8000, 0, 1'b1, '{9000, 16384, -16384, 0});
    send_sample(100, 0, 100, 1'b0, '{0, 0, 0, 0});
    drain();
    // Divisor zero acts as one; gain zero drives every average to zero.
    write_reg(REG_DIV, 16'd0);
    write_reg(REG_GAIN, 16'd0);
    send_sample(1234, -5, 77, 1'b1, '{0, 0, 0, 0});
    drain();

    // Phase A: sender idles a quarter of the time, receiver three quarters.
    write_reg(REG_GAIN, 16'd16357);
    write_reg(REG_DIV, 16'd8);
    send_idle_pct = 25; recv_idle_pct = 76;
    random_samples(450);
    drain();

    // Phase B: swapped idling, maximum gain and divisor.
    write_reg(REG_GAIN, 16'hffff);
    write_reg(REG_DIV, 16'd255);
    send_idle_pct = 76; recv_idle_pct = 25;
    random_samples(450);
    drain();

    // Phase C: no idling, random settings; includes a long receiver hold.
    write_reg(REG_GAIN, 16'($urandom_range(65535)));
    write_reg(REG_DIV, 16'($urandom_range(1, 16)));
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_recv = 1'b0;
      end
      random_samples(30);
    join
    // Sender pauses until everything has come back, then carries on.
    drain();
    write_reg(REG_DIV, 16'd2);
    random_samples(470);

    drain();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
